// ----- design/text_console_cursor_scroll_defines.svh -----
// ---------------------------------------------------------------------------
// Text console assertion macros
// Shared property macros for the console checker.
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_DEFINES_SVH

// same-cycle implication
`define TCCS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/tccs_pkg.sv -----
// ---------------------------------------------------------------------------
// Text console package
// Field widths, stream packing and cell constants.
// ---------------------------------------------------------------------------
package tccs_pkg;

  localparam int CHAR_W = 8;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CELL_W = 16;
  localparam int COLOR_W = 8;

  // input tdata: char_code, read_row, read_column
  localparam int IN_CHAR_LSB = 0;
  localparam int IN_ROW_LSB  = IN_CHAR_LSB + CHAR_W;
  localparam int IN_COL_LSB  = IN_ROW_LSB + ROW_W;
  localparam int IN_TDATA_W  = 24;

  // output tdata: cell_value, cursor_row_out, cursor_column_out, scrolled
  localparam int OUT_USED_W  = CELL_W + ROW_W + COL_W + 1;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [CHAR_W-1:0]  NEWLINE_CODE   = 8'd10;
  localparam logic [CHAR_W-1:0]  SPACE_CODE     = 8'h20;
  localparam logic [COLOR_W-1:0] COLOR_AT_RESET = 8'h0C;

  function automatic logic [CELL_W-1:0] make_cell(input logic [CHAR_W-1:0] ch,
                                                  input logic [COLOR_W-1:0] color);
    return {color, ch};
  endfunction

endpackage

// ----- design/tccs_ram.sv -----
// ---------------------------------------------------------------------------
// Screen cell RAM
// Single-port memory, one write and one read per cycle at the same address, registered read data.
// ---------------------------------------------------------------------------
module tccs_ram
  import tccs_pkg::*;
#(
  parameter int AW = 12
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     addr,
  input  logic [CELL_W-1:0] wdata,
  output logic [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [(1 << AW)];
  logic [CELL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ----- design/tccs_addr.sv -----
// ---------------------------------------------------------------------------
// Screen address unit
// Maps a logical row through the scroll base to a physical RAM address.
// ---------------------------------------------------------------------------
module tccs_addr #(
  parameter int SCREEN_HEIGHT = 25,
  parameter int RW = 5,
  parameter int CW = 7
) (
  input  logic [RW-1:0]    base,
  input  logic [RW-1:0]    row,
  input  logic [CW-1:0]    col,
  output logic [RW+CW-1:0] addr
);

  logic [RW:0]   sum;
  logic [RW-1:0] prow;

  always_comb begin
    sum = {1'b0, base} + {1'b0, row};
    if (32'(sum) >= 32'(SCREEN_HEIGHT)) begin
      prow = RW'(32'(sum) - 32'(SCREEN_HEIGHT));
    end else begin
      prow = sum[RW-1:0];
    end
    addr = {prow, col};
  end

endmodule

// ----- design/text_console_cursor_scroll.sv -----
// ---------------------------------------------------------------------------
// Text console with cursor and scroll
// Cell screen in RAM, rows rotated through a base offset, bottom row cleared
// by a sweep on scroll.
// ---------------------------------------------------------------------------
// channel | direction | handshake             | payload
// in      | slave     | in_tvalid/in_tready   | tuser op, tdata char/row/col
// out     | master    | out_tvalid/out_tready | tdata cell/row/col/scrolled
// cfg     | slave     | cfg_valid/cfg_ready   | cfg_data text color
//
// Put and out-of-range read pass ST_EXEC and ST_OUT before the result is registered;
// an in-range read adds ST_RDATA between them for the registered RAM read.
// A put that moves below the bottom row (newline or wrap past the last column)
// adds a bottom-row clear in ST_CLEAR, one cell per cycle.
// After reset the whole screen is cleared in ST_INIT with in_tready low;
// cfg writes are taken throughout.
// A new item is taken while a result waits; a stalled output holds the
// next result in the block until out_tready.
// ---------------------------------------------------------------------------
module text_console_cursor_scroll
  import tccs_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 80,
  parameter int SCREEN_HEIGHT = 25
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // char_code, read_row, read_column
  input  logic                   in_tuser,   // operation
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // cell_value, cursor_row_out,
                                             // cursor_column_out, scrolled
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [COLOR_W-1:0]     cfg_data
);

  localparam int RW = $clog2(SCREEN_HEIGHT);
  localparam int CW = $clog2(SCREEN_WIDTH);
  localparam int AW = RW + CW;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_RDATA,
    ST_CLEAR,
    ST_OUT
  } state_t;

  state_t state_r, state_nxt;

  logic [RW-1:0]      cur_row_r, cur_row_nxt;
  logic [CW-1:0]      cur_col_r, cur_col_nxt;
  logic [RW-1:0]      base_r, base_nxt;
  logic [RW-1:0]      clr_row_r, clr_row_nxt;
  logic [CW-1:0]      clr_col_r, clr_col_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [COLOR_W-1:0] text_color_r, text_color_nxt;

  logic               op_r, op_nxt;
  logic [CHAR_W-1:0]  char_r, char_nxt;
  logic [ROW_W-1:0]   rr_r, rr_nxt;
  logic [COL_W-1:0]   rc_r, rc_nxt;
  logic [CELL_W-1:0]  cell_r, cell_nxt;
  logic               scrolled_r, scrolled_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic [RW-1:0]     au_base;
  logic [RW-1:0]     au_row;
  logic [CW-1:0]     au_col;
  logic [AW-1:0]     ram_addr;
  logic              ram_we;
  logic [CELL_W-1:0] ram_wdata;
  logic [CELL_W-1:0] ram_rdata;

  logic in_fire;
  logic out_free;
  logic clr_col_last;
  logic clr_row_last;

  tccs_addr #(
    .SCREEN_HEIGHT(SCREEN_HEIGHT),
    .RW(RW),
    .CW(CW)
  ) u_addr (
    .base (au_base),
    .row  (au_row),
    .col  (au_col),
    .addr (ram_addr)
  );

  tccs_ram #(
    .AW(AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = 1'b1;

  assign clr_col_last = (32'(clr_col_r) == 32'(SCREEN_WIDTH - 1));
  assign clr_row_last = (32'(clr_row_r) == 32'(SCREEN_HEIGHT - 1));

  always_comb begin
    state_nxt      = state_r;
    cur_row_nxt    = cur_row_r;
    cur_col_nxt    = cur_col_r;
    base_nxt       = base_r;
    clr_row_nxt    = clr_row_r;
    clr_col_nxt    = clr_col_r;
    out_valid_nxt  = out_valid_r;
    text_color_nxt = text_color_r;
    op_nxt         = op_r;
    char_nxt       = char_r;
    rr_nxt         = rr_r;
    rc_nxt         = rc_r;
    cell_nxt       = cell_r;
    scrolled_nxt   = scrolled_r;
    out_data_nxt   = out_data_r;

    au_base   = base_r;
    au_row    = cur_row_r;
    au_col    = cur_col_r;
    ram_we    = 1'b0;
    ram_wdata = make_cell(char_r, text_color_r);

    if (cfg_valid) begin
      text_color_nxt = cfg_data;
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_INIT: begin
        au_base   = '0;
        au_row    = clr_row_r;
        au_col    = clr_col_r;
        ram_we    = 1'b1;
        ram_wdata = make_cell(SPACE_CODE, COLOR_AT_RESET);
        if (clr_col_last) begin
          clr_col_nxt = '0;
          clr_row_nxt = clr_row_r + RW'(1);
          if (clr_row_last) begin
            clr_row_nxt = '0;
            state_nxt   = ST_IDLE;
          end
        end else begin
          clr_col_nxt = clr_col_r + CW'(1);
        end
      end

      ST_IDLE: begin
        if (in_fire) begin
          op_nxt    = in_tuser;
          char_nxt  = in_tdata[IN_CHAR_LSB +: CHAR_W];
          rr_nxt    = in_tdata[IN_ROW_LSB +: ROW_W];
          rc_nxt    = in_tdata[IN_COL_LSB +: COL_W];
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        cell_nxt     = '0;
        scrolled_nxt = 1'b0;
        state_nxt    = ST_OUT;
        if (op_r == OP_READ) begin
          au_row = RW'(rr_r);
          au_col = CW'(rc_r);
          if ((32'(rr_r) < 32'(SCREEN_HEIGHT)) && (32'(rc_r) < 32'(SCREEN_WIDTH))) begin
            state_nxt = ST_RDATA;
          end
        end else begin
          if (char_r != NEWLINE_CODE) begin
            ram_we = 1'b1;
          end
          if ((char_r == NEWLINE_CODE) ||
              (32'(cur_col_r) == 32'(SCREEN_WIDTH - 1))) begin
            cur_col_nxt = '0;
            if (32'(cur_row_r) == 32'(SCREEN_HEIGHT - 1)) begin
              scrolled_nxt = 1'b1;
              clr_row_nxt  = base_r;
              clr_col_nxt  = '0;
              base_nxt     = (32'(base_r) == 32'(SCREEN_HEIGHT - 1)) ? '0
                                                                      : base_r + RW'(1);
              state_nxt    = ST_CLEAR;
            end else begin
              cur_row_nxt = cur_row_r + RW'(1);
            end
          end else begin
            cur_col_nxt = cur_col_r + CW'(1);
          end
        end
      end

      ST_RDATA: begin
        cell_nxt  = ram_rdata;
        state_nxt = ST_OUT;
      end

      ST_CLEAR: begin
        // clr_row_r holds the physical row, so no base offset here
        au_base   = '0;
        au_row    = clr_row_r;
        au_col    = clr_col_r;
        ram_we    = 1'b1;
        ram_wdata = make_cell(SPACE_CODE, text_color_r);
        if (clr_col_last) begin
          clr_col_nxt = '0;
          state_nxt   = ST_OUT;
        end else begin
          clr_col_nxt = clr_col_r + CW'(1);
        end
      end

      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {{OUT_PAD_W{1'b0}}, scrolled_r, COL_W'(cur_col_r),
                           ROW_W'(cur_row_r), cell_r};
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      cur_row_r    <= '0;
      cur_col_r    <= '0;
      base_r       <= '0;
      clr_row_r    <= '0;
      clr_col_r    <= '0;
      out_valid_r  <= 1'b0;
      text_color_r <= COLOR_AT_RESET;
    end else begin
      state_r      <= state_nxt;
      cur_row_r    <= cur_row_nxt;
      cur_col_r    <= cur_col_nxt;
      base_r       <= base_nxt;
      clr_row_r    <= clr_row_nxt;
      clr_col_r    <= clr_col_nxt;
      out_valid_r  <= out_valid_nxt;
      text_color_r <= text_color_nxt;
    end
    op_r       <= op_nxt;
    char_r     <= char_nxt;
    rr_r       <= rr_nxt;
    rc_r       <= rc_nxt;
    cell_r     <= cell_nxt;
    scrolled_r <= scrolled_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ----- design/tccs_checker.sv -----
// ---------------------------------------------------------------------------
// Text console port checker
// Port-level properties of the console, bound to the top level.
// ---------------------------------------------------------------------------
`include "text_console_cursor_scroll_defines.svh"

module tccs_checker
  import tccs_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 80,
  parameter int SCREEN_HEIGHT = 25
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(SCREEN_HEIGHT - 1);

  `TCCS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")

  `TCCS_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_tvalid && in_tready, !in_tready, "input ready right after a transfer")

  `TCCS_ASSERT_NOW(a_cursor_range, clk, rst_n, out_tvalid, (32'(out_tdata[20:16]) < 32'(SCREEN_HEIGHT)) && (32'(out_tdata[27:21]) < 32'(SCREEN_WIDTH)), "cursor off screen")

  `TCCS_ASSERT_NOW(a_scroll_cursor, clk, rst_n, out_tvalid && out_tdata[28], (out_tdata[27:21] == 7'd0) && (out_tdata[20:16] == ROW_LAST), "scroll left cursor off bottom row start")

endmodule

bind text_console_cursor_scroll tccs_checker #(
  .SCREEN_WIDTH(SCREEN_WIDTH),
  .SCREEN_HEIGHT(SCREEN_HEIGHT)
) u_tccs_checker (.*);

// ----- tb/text_console_cursor_scroll_test.sv -----
// ---------------------------------------------------------------------------
// Text console cursor and scroll testbench
// Drives put and read transfers into the console. Each result is checked
// against a typed value from the directed table or else against a mirror of
// the screen, the cursor and the text color that this bench keeps. A directed
// table comes first. Random phases of line-shaped text follow, and each phase
// starts with a new text color. Both stream sides idle in random bursts.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module text_console_cursor_scroll_test;
  import tccs_pkg::*;

  localparam int COLS           = 80;
  localparam int ROWS           = 25;
  localparam int OUT_ROW_LSB    = CELL_W;
  localparam int OUT_COL_LSB    = OUT_ROW_LSB + ROW_W;
  localparam int OUT_SCROLL_BIT = OUT_COL_LSB + COL_W;
  localparam int NUM_DIRECTED   = 20;
  localparam int NUM_PHASES     = 5;
  localparam int PHASE_ITEMS    = 230;
  localparam int SETTLE_CYCLES  = 120;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int MAX_PRINTED    = 40;

  typedef struct packed {
    logic [CELL_W-1:0] cell_val;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              scrolled;
  } console_result_t;

  typedef struct packed {
    logic              op;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  rr;
    logic [COL_W-1:0]  rc;
    logic              typed;
    console_result_t   res;
  } directed_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // char_code, read_row, read_column
  logic                   in_tuser = 1'b0; // operation
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // cell_value, cursor_row_out,
                                           // cursor_column_out, scrolled
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [COLOR_W-1:0]     cfg_data = '0;

  text_console_cursor_scroll dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // screen mirror
  logic [CELL_W-1:0]  screen_mirror [ROWS][COLS];
  logic [ROW_W-1:0]   cur_row = '0;
  logic [COL_W-1:0]   cur_col = '0;
  logic [COLOR_W-1:0] color_mirror = COLOR_AT_RESET;

  console_result_t expected_results [$];
  directed_row_t   directed_tbl [NUM_DIRECTED];

  int mismatch_count = 0;
  int results_seen   = 0;
  int scrolls_seen   = 0;
  int items_sent     = 0;
  int reads_sent     = 0;
  int newlines_sent  = 0;
  int color_writes   = 0;
  int in_idle_pct    = 0;
  int out_stall_pct  = 0;
  int stall_left     = 0;
  int quiet_cycles   = 0;

  function automatic console_result_t console_step(input logic op,
                                                   input logic [CHAR_W-1:0] ch,
                                                   input logic [ROW_W-1:0] rr,
                                                   input logic [COL_W-1:0] rc);
    console_result_t r;
    logic            wrap;
    r    = '0;
    wrap = 1'b0;
    if (op == OP_READ) begin
      if (32'(rr) < ROWS && 32'(rc) < COLS) r.cell_val = screen_mirror[rr][rc];
    end else if (ch == NEWLINE_CODE) begin
      wrap = 1'b1;
    end else begin
      screen_mirror[cur_row][cur_col] = {color_mirror, ch};
      if (32'(cur_col) == COLS - 1) wrap = 1'b1;
      else cur_col = cur_col + COL_W'(1);
    end
    if (wrap) begin
      cur_col = '0;
      if (32'(cur_row) == ROWS - 1) begin
        for (int y = 0; y < ROWS - 1; y++)
          for (int x = 0; x < COLS; x++)
            screen_mirror[y][x] = screen_mirror[y+1][x];
        for (int x = 0; x < COLS; x++)
          screen_mirror[ROWS-1][x] = {color_mirror, SPACE_CODE};
        r.scrolled = 1'b1;
      end else begin
        cur_row = cur_row + ROW_W'(1);
      end
    end
    r.row = cur_row;
    r.col = cur_col;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED)
      $display("%0t ns  result %0d %s: got 0x%0h, expected 0x%0h",
               $time, results_seen, what, got, want);
  endtask

  task automatic send_item(input logic op, input logic [CHAR_W-1:0] ch,
                           input logic [ROW_W-1:0] rr, input logic [COL_W-1:0] rc,
                           input logic typed, input console_result_t typed_res);
    logic [IN_TDATA_W-1:0] word;
    console_result_t       predicted;
    if ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    word = '0;
    word[IN_CHAR_LSB +: CHAR_W] = ch;
    word[IN_ROW_LSB  +: ROW_W]  = rr;
    word[IN_COL_LSB  +: COL_W]  = rc;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    predicted = console_step(op, ch, rr, rc);
    expected_results.push_back(typed ? typed_res : predicted);
    items_sent++;
    if (op == OP_READ) reads_sent++;
    else if (ch == NEWLINE_CODE) newlines_sent++;
  endtask

  // hold off input until every result is back; the block is idle afterwards
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic write_color(input logic [COLOR_W-1:0] color);
    cfg_valid <= 1'b1;
    cfg_data  <= color;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    color_mirror  = color;
    color_writes++;
  endtask

  // result sink with random stall bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (rst_n && $urandom_range(99) < out_stall_pct) begin
      stall_left <= $urandom_range(9);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    console_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transfer", out_tdata, '0);
      end else begin
        want = expected_results.pop_front();
        if (out_tdata[CELL_W-1:0] != want.cell_val)
          report_mismatch("cell_value", 32'(out_tdata[CELL_W-1:0]), 32'(want.cell_val));
        if (out_tdata[OUT_ROW_LSB +: ROW_W] != want.row)
          report_mismatch("cursor_row_out", 32'(out_tdata[OUT_ROW_LSB +: ROW_W]),
                          32'(want.row));
        if (out_tdata[OUT_COL_LSB +: COL_W] != want.col)
          report_mismatch("cursor_column_out", 32'(out_tdata[OUT_COL_LSB +: COL_W]),
                          32'(want.col));
        if (out_tdata[OUT_SCROLL_BIT] != want.scrolled)
          report_mismatch("scrolled", 32'(out_tdata[OUT_SCROLL_BIT]), 32'(want.scrolled));
        if (want.scrolled) scrolls_seen++;
      end
      results_seen++;
    end
  end

  // watchdog: cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results pending",
               quiet_cycles, expected_results.size());
      $display("text_console_cursor_scroll_test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [COLOR_W-1:0] phase_color [NUM_PHASES];
    int                 phase_idle  [NUM_PHASES];
    int                 phase_stall [NUM_PHASES];
    int                 line_left;
    int unsigned        pick;
    logic               op;
    logic [CHAR_W-1:0]  ch;
    logic [ROW_W-1:0]   rr;
    logic [COL_W-1:0]   rc;

    for (int y = 0; y < ROWS; y++)
      for (int x = 0; x < COLS; x++)
        screen_mirror[y][x] = {COLOR_AT_RESET, SPACE_CODE};

    directed_tbl = '{
      '{OP_READ, 8'h00, 5'd0,  7'd0,   1'b1, {16'h0C20, 5'd0, 7'd0, 1'b0}},
      '{OP_READ, 8'h00, 5'd24, 7'd79,  1'b1, {16'h0C20, 5'd0, 7'd0, 1'b0}},
      '{OP_READ, 8'h00, 5'd25, 7'd0,   1'b1, {16'h0000, 5'd0, 7'd0, 1'b0}},
      '{OP_READ, 8'h00, 5'd0,  7'd80,  1'b1, {16'h0000, 5'd0, 7'd0, 1'b0}},
      '{OP_READ, 8'hFF, 5'd31, 7'd127, 1'b1, {16'h0000, 5'd0, 7'd0, 1'b0}},
      '{OP_PUT,  8'h41, 5'd0,  7'd0,   1'b1, {16'h0000, 5'd0, 7'd1, 1'b0}},
      '{OP_PUT,  8'h00, 5'd0,  7'd0,   1'b1, {16'h0000, 5'd0, 7'd2, 1'b0}},
      '{OP_PUT,  8'hFF, 5'd31, 7'd127, 1'b1, {16'h0000, 5'd0, 7'd3, 1'b0}},
      '{OP_READ, 8'h00, 5'd0,  7'd2,   1'b1, {16'h0CFF, 5'd0, 7'd3, 1'b0}},
      '{OP_READ, 8'h00, 5'd0,  7'd0,   1'b1, {16'h0C41, 5'd0, 7'd3, 1'b0}},
      '{OP_PUT,  NEWLINE_CODE, 5'd0, 7'd0, 1'b1, {16'h0000, 5'd1, 7'd0, 1'b0}},
      '{OP_PUT,  8'h80, 5'd17, 7'd99,  1'b0, '0},
      '{OP_PUT,  8'h7F, 5'd0,  7'd0,   1'b0, '0},
      '{OP_READ, 8'h00, 5'd1,  7'd0,   1'b0, '0},
      '{OP_READ, 8'h00, 5'd1,  7'd1,   1'b0, '0},
      '{OP_PUT,  NEWLINE_CODE, 5'd31, 7'd127, 1'b0, '0},
      '{OP_PUT,  NEWLINE_CODE, 5'd0,  7'd0,   1'b0, '0},
      '{OP_READ, 8'h00, 5'd24, 7'd79,  1'b0, '0},
      '{OP_PUT,  SPACE_CODE, 5'd0, 7'd0, 1'b0, '0},
      '{OP_READ, 8'h00, 5'd3,  7'd0,   1'b0, '0}
    };

    phase_color = '{8'h00, 8'hFF, 8'h00, 8'hA5, 8'h00};
    phase_color[2] = COLOR_W'($urandom_range(255));
    phase_color[4] = COLOR_W'($urandom_range(255));
    phase_idle  = '{30, 0, 60, 15, 0};
    phase_stall = '{30, 50, 0, 15, 0};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    in_idle_pct   = 20;
    out_stall_pct = 20;
    foreach (directed_tbl[i])
      send_item(directed_tbl[i].op, directed_tbl[i].ch, directed_tbl[i].rr,
                directed_tbl[i].rc, directed_tbl[i].typed, directed_tbl[i].res);

    line_left = 0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      write_color(phase_color[p]);
      in_idle_pct   = phase_idle[p];
      out_stall_pct = phase_stall[p];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        rr = ROW_W'($urandom_range(31));
        rc = COL_W'($urandom_range(127));
        ch = CHAR_W'($urandom_range(255));
        pick = $urandom_range(99);
        if (pick < 25) begin
          op   = OP_READ;
          pick = $urandom_range(99);
          if (pick < 45) begin
            rr = (cur_row != '0 && $urandom_range(1) == 1) ? cur_row - ROW_W'(1) : cur_row;
            rc = COL_W'($urandom_range(COLS - 1));
          end else if (pick < 90) begin
            rr = ROW_W'($urandom_range(ROWS - 1));
            rc = COL_W'($urandom_range(COLS - 1));
          end
        end else begin
          op = OP_PUT;
          if (line_left == 0) begin
            ch        = NEWLINE_CODE;
            line_left = ($urandom_range(3) == 0) ? $urandom_range(70, 100)
                                                 : $urandom_range(40);
          end else begin
            line_left--;
          end
        end
        send_item(op, ch, rr, rc, 1'b0, '0);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d transfers in (%0d reads, %0d newlines), %0d results, %0d scrolls",
             items_sent, reads_sent, newlines_sent, results_seen, scrolls_seen);
    $display("%0d text color writes, %0d mismatches", color_writes, mismatch_count);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("text_console_cursor_scroll_test passed");
    end else begin
      $display("text_console_cursor_scroll_test failed");
    end
    $finish;
  end

endmodule
